// ===== hw/rtl/ctsc_pkg.sv =====
// Package for the processor time share calculator.
// Holds the sequencer state type, job codes and fixed field widths.
// No dependencies.
package ctsc_pkg;

    localparam int SLOT_BITS  = 6;
    localparam int TICK_BITS  = 64;
    localparam int SHARE_BITS = 15;
    localparam int NUM_CTR    = 8;
    localparam int CTR_IDX_BITS = 3;
    localparam int CNT_BITS   = 4;
    localparam int MUL_GROW   = 7;   // bits added by the multiply by 100

    // counter positions inside one snapshot
    localparam int CTR_USER    = 0;
    localparam int CTR_NICE    = 1;
    localparam int CTR_SYSTEM  = 2;
    localparam int CTR_IDLE    = 3;
    localparam int CTR_IOWAIT  = 4;
    localparam int CTR_IRQ     = 5;
    localparam int CTR_SOFTIRQ = 6;
    localparam int CTR_STEAL   = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_PREP,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_WAIT,
        S_WRITE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        JOB_BUSY,
        JOB_USER,
        JOB_SYSTEM,
        JOB_IOWAIT,
        JOB_IRQ,
        JOB_SOFTIRQ
    } job_t;

endpackage

// ===== hw/rtl/ctsc_ram.sv =====
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module ctsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ctsc_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ctsc_divider #(
    parameter int DIVIDEND_BITS = 79,
    parameter int DIVISOR_BITS  = 64,
    parameter int QUOTIENT_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [QUOTIENT_BITS-1:0] quotient
);

    localparam int CW = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] num_reg, num_next;
    logic [DIVISOR_BITS-1:0]  den_reg, den_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [QUOTIENT_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    // remainder stays below the divisor, so one extra bit holds the trial
    assign trial = {rem_reg, num_reg[DIVIDEND_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
            quo_next = '0;
            cnt_next = CW'(DIVIDEND_BITS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = num_reg << 1;
            rem_next = fits ? DIVISOR_BITS'(trial - {1'b0, den_reg})
                            : trial[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[QUOTIENT_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/cpu_time_share_calculator_top.sv =====
// Processor time share calculator, top level: sequencer, snapshot store, divider.
// Depends on ctsc_pkg, ctsc_ram and ctsc_divider.
//
// Each input transaction carries one snapshot of eight cumulative tick counters
// for a processor slot. The block subtracts the snapshot last stored for that
// slot (modulo 2^COUNTER_BITS), or takes the raw counts on the slot's first
// snapshot or when the slot number is not below CPU_SLOTS, sums the eight
// differences into a total, and returns busy, user+nice, system, iowait, irq
// and softirq shares of that total as percent times 2^FRACTION_BITS, floored
// and clamped to full scale; all shares read zero when the total is zero.
// The dividend of the divider is DIVIDEND_BITS = COUNTER_BITS + 7 + FRACTION_BITS
// bits wide. The six divisions run one after another on a single radix-2
// divider, one quotient bit per cycle; a share whose part is not below the
// total skips its division. in_stall stays high from accept until the result
// is loaded into the output register, and a held result does not stop the
// next transaction from being accepted. The snapshot store is a RAM of
// CPU_SLOTS*8 words read and written one counter per cycle; it needs no
// clearing, since a slot's stored words are used only after its seen flag,
// held in flip-flops and cleared by reset, is set.
module cpu_time_share_calculator_top #(
    parameter int CPU_SLOTS     = 64,
    parameter int COUNTER_BITS  = 64,
    parameter int FRACTION_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ctsc_pkg::SLOT_BITS-1:0]   cpu_slot,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   user_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   nice_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   system_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   idle_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   iowait_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   irq_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   softirq_ticks,
    input  logic [ctsc_pkg::TICK_BITS-1:0]   steal_ticks,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ctsc_pkg::SLOT_BITS-1:0]   result_slot,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  busy_share,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  user_share,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  system_share,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  iowait_share,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  irq_share,
    output logic [ctsc_pkg::SHARE_BITS-1:0]  softirq_share,
    output logic                             since_start,
    output logic                             total_nonzero
);

    import ctsc_pkg::*;

    localparam int CB         = COUNTER_BITS;
    localparam int FULL_SCALE = 100 * (2 ** FRACTION_BITS);
    localparam int QB         = $clog2(FULL_SCALE + 1);
    localparam int PB         = CB + MUL_GROW;          // part times 100
    localparam int DB         = PB + FRACTION_BITS;     // dividend width
    localparam int RAM_DEPTH  = CPU_SLOTS * NUM_CTR;
    localparam int AW         = $clog2(RAM_DEPTH);
    localparam int SIW        = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
    localparam int NUM_SHARES = 6;

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic                 first_reg, first_next;
    logic                 in_range_reg, in_range_next;
    logic [CB-1:0]        cur_reg [NUM_CTR];
    logic [CB-1:0]        cur_next [NUM_CTR];
    logic [CB-1:0]        d_reg [NUM_CTR];
    logic [CB-1:0]        d_next [NUM_CTR];
    logic [CB-1:0]        total_reg, total_next;
    logic [CB-1:0]        part_reg, part_next;
    logic                 zero_reg, zero_next;
    logic [PB-1:0]        prod_reg, prod_next;
    logic [SHARE_BITS-1:0] share_reg [NUM_SHARES];
    logic [SHARE_BITS-1:0] share_next [NUM_SHARES];
    logic [CPU_SLOTS-1:0] seen_reg, seen_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0] out_slot_reg, out_slot_next;
    logic [SHARE_BITS-1:0] out_share_reg [NUM_SHARES];
    logic [SHARE_BITS-1:0] out_share_next [NUM_SHARES];
    logic                 out_first_reg, out_first_next;
    logic                 out_nz_reg, out_nz_next;

    logic                 in_accept;
    logic                 out_take;
    logic [CTR_IDX_BITS-1:0] cur_idx;
    logic [CTR_IDX_BITS-1:0] lag_idx;
    logic [SIW-1:0]       seen_idx;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_addr;
    logic [CB-1:0]        ram_rd_data;
    logic                 div_start;
    logic                 div_done;
    logic [QB-1:0]        div_quotient;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign seen_idx  = SIW'(cpu_slot);

    // the read data for counter cnt-1 arrives while counter cnt is addressed
    assign lag_idx = CTR_IDX_BITS'(cnt_reg - 1'b1);
    assign cur_idx = (state_reg == S_READ) ? lag_idx : cnt_reg[CTR_IDX_BITS-1:0];
    assign ram_addr = AW'({slot_reg, cnt_reg[CTR_IDX_BITS-1:0]});
    assign ram_wr_en = (state_reg == S_WRITE) && in_range_reg;

    ctsc_ram #(
        .WIDTH (CB),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (cur_reg[cur_idx]),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    ctsc_divider #(
        .DIVIDEND_BITS (DB),
        .DIVISOR_BITS  (CB),
        .QUOTIENT_BITS (QB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DB'(prod_reg) << FRACTION_BITS),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        first_next     = first_reg;
        in_range_next  = in_range_reg;
        cur_next       = cur_reg;
        d_next         = d_reg;
        total_next     = total_reg;
        part_next      = part_reg;
        zero_next      = zero_reg;
        prod_next      = prod_reg;
        share_next     = share_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_share_next = out_share_reg;
        out_first_next = out_first_reg;
        out_nz_next    = out_nz_reg;
        div_start      = 1'b0;

        // drop the held result once the receiver takes it
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // latch the snapshot and decide first or delta
                    slot_next     = cpu_slot;
                    in_range_next = (9'(cpu_slot) < 9'(CPU_SLOTS));
                    first_next    = !((9'(cpu_slot) < 9'(CPU_SLOTS)) && seen_reg[seen_idx]);
                    cur_next[CTR_USER]    = CB'(user_ticks);
                    cur_next[CTR_NICE]    = CB'(nice_ticks);
                    cur_next[CTR_SYSTEM]  = CB'(system_ticks);
                    cur_next[CTR_IDLE]    = CB'(idle_ticks);
                    cur_next[CTR_IOWAIT]  = CB'(iowait_ticks);
                    cur_next[CTR_IRQ]     = CB'(irq_ticks);
                    cur_next[CTR_SOFTIRQ] = CB'(softirq_ticks);
                    cur_next[CTR_STEAL]   = CB'(steal_ticks);
                    for (int i = 0; i < NUM_SHARES; i++)
                    begin
                        share_next[i] = '0;
                    end
                    total_next = '0;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                // address counter cnt, take the data of counter cnt-1
                if (cnt_reg != '0)
                begin
                    d_next[lag_idx] = first_reg ? cur_reg[cur_idx]
                                                : cur_reg[cur_idx] - ram_rd_data;
                end
                if (cnt_reg == CNT_BITS'(NUM_CTR))
                begin
                    cnt_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SUM:
            begin
                total_next = total_reg + d_reg[cnt_reg[CTR_IDX_BITS-1:0]];
                if (cnt_reg == CNT_BITS'(NUM_CTR - 1))
                begin
                    job_next   = JOB_BUSY;
                    state_next = S_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_PREP:
            begin
                zero_next = 1'b0;
                case (job_reg)
                    JOB_BUSY:
                    begin
                        part_next = total_reg - d_reg[CTR_IDLE];
                        zero_next = d_reg[CTR_IDLE] > total_reg;
                    end
                    JOB_USER:    part_next = d_reg[CTR_USER] + d_reg[CTR_NICE];
                    JOB_SYSTEM:  part_next = d_reg[CTR_SYSTEM];
                    JOB_IOWAIT:  part_next = d_reg[CTR_IOWAIT];
                    JOB_IRQ:     part_next = d_reg[CTR_IRQ];
                    JOB_SOFTIRQ: part_next = d_reg[CTR_SOFTIRQ];
                    default:     part_next = '0;
                endcase
                if (total_reg == '0)
                begin
                    // zero total: every share stays zero
                    cnt_next   = '0;
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (zero_reg || (part_reg >= total_reg))
                begin
                    share_next[job_reg] = zero_reg ? '0 : SHARE_BITS'(FULL_SCALE);
                    if (job_reg == JOB_SOFTIRQ)
                    begin
                        cnt_next   = '0;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        job_next   = job_t'(job_reg + 1'b1);
                        state_next = S_PREP;
                    end
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end

            S_MUL1:
            begin
                // part * 100 = part*64 + part*32 + part*4
                prod_next  = (PB'(part_reg) << 6) + (PB'(part_reg) << 5);
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                prod_next  = prod_reg + (PB'(part_reg) << 2);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                if (div_done)
                begin
                    share_next[job_reg] = SHARE_BITS'(div_quotient);
                    if (job_reg == JOB_SOFTIRQ)
                    begin
                        cnt_next   = '0;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        job_next   = job_t'(job_reg + 1'b1);
                        state_next = S_PREP;
                    end
                end
            end

            S_WRITE:
            begin
                // store the new snapshot, one counter per cycle
                if (cnt_reg == CNT_BITS'(NUM_CTR - 1))
                begin
                    if (in_range_reg)
                    begin
                        seen_next[SIW'(slot_reg)] = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_reg;
                    out_share_next = share_reg;
                    out_first_next = first_reg;
                    out_nz_next    = (total_reg != '0);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_BUSY;
            cnt_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        first_reg     <= first_next;
        in_range_reg  <= in_range_next;
        cur_reg       <= cur_next;
        d_reg         <= d_next;
        total_reg     <= total_next;
        part_reg      <= part_next;
        zero_reg      <= zero_next;
        prod_reg      <= prod_next;
        share_reg     <= share_next;
        out_slot_reg  <= out_slot_next;
        out_share_reg <= out_share_next;
        out_first_reg <= out_first_next;
        out_nz_reg    <= out_nz_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_slot   = out_slot_reg;
    assign busy_share    = out_share_reg[JOB_BUSY];
    assign user_share    = out_share_reg[JOB_USER];
    assign system_share  = out_share_reg[JOB_SYSTEM];
    assign iowait_share  = out_share_reg[JOB_IOWAIT];
    assign irq_share     = out_share_reg[JOB_IRQ];
    assign softirq_share = out_share_reg[JOB_SOFTIRQ];
    assign since_start   = out_first_reg;
    assign total_nonzero = out_nz_reg;

endmodule
